[src/fdtr_pkg.sv]
// Shared types and constants of the fragment decode time restamper.
package fdtr_pkg;

	localparam logic [31:0] TYPE_MOOF = 32'h6D6F6F66;
	localparam logic [31:0] TYPE_TRAF = 32'h74726166;
	localparam logic [31:0] TYPE_TFDT = 32'h74666474;

	localparam logic [3:0] HDR_LEN = 4'd8;
	localparam logic [3:0] PREFIX_LEN = 4'd4;
	localparam logic [3:0] TIME_LEN_NARROW = 4'd4;
	localparam logic [3:0] TIME_LEN_WIDE = 4'd8;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIME = 1'b1;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  count;
		logic        last;
		logic        first_valid;
		logic [63:0] time_before;
		logic [63:0] after;
		logic        malformed;
	} cmd_t;

endpackage

[src/fragment_decode_time_restamper.sv]
// Top level of the decode time restamper: configuration, parser, queue and serializer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | push / full          | data_byte, end_of_segment
//  result   | empty / pop          | out_byte, out_last, first_time_valid,
//           |                      | first_time_before, first_time_after, malformed
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte is accepted per cycle while full is low; the parser classifies it in that cycle.
// The serializer sends one beat per cycle while the queue is not empty and the result side pops;
// a finished time field leaves as four or eight beats from one queue entry, and a byte passes through a
// queue entry and then the result register before it reaches the result ports, behind any queue backlog.
// The four-entry command queue lets the input and result sides stall independently.
// Reset empties the queue and the result register and clears the parser and both configuration registers.
module fragment_decode_time_restamper #(
	parameter int NEST_DEPTH = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_segment,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_byte,
	output logic                           out_last,
	output logic                           first_time_valid,
	output logic [63:0]                    first_time_before,
	output logic [63:0]                    first_time_after,
	output logic                           malformed,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fdtr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	import fdtr_pkg::*;

	logic [63:0] offset_q, base_q, delta_q;
	logic        in_fire, f_valid, q_full, q_empty, q_rd;
	cmd_t        f_cmd, q_head;

	assign cfg_ready = 1'b1;
	assign in_fire = push && !q_full;
	assign full = q_full;

	// The front adds one precomputed difference instead of subtracting and adding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 64'd0;
			base_q <= 64'd0;
			delta_q <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIME_OFFSET: begin
					offset_q <= cfg_data;
					delta_q <= cfg_data - base_q;
				end
				CFG_BASE_TIME: begin
					base_q <= cfg_data;
					delta_q <= offset_q - cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	fdtr_front #(
		.NEST_DEPTH(NEST_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.data_byte(data_byte),
		.end_of_segment(end_of_segment),
		.delta(delta_q),
		.cmd_valid(f_valid),
		.cmd(f_cmd)
	);

	fdtr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(f_valid),
		.wr_cmd(f_cmd),
		.full(q_full),
		.rd_en(q_rd),
		.rd_cmd(q_head),
		.empty(q_empty)
	);

	fdtr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(q_empty),
		.cmd(q_head),
		.cmd_rd(q_rd),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.out_last(out_last),
		.first_time_valid(first_time_valid),
		.first_time_before(first_time_before),
		.first_time_after(first_time_after),
		.malformed(malformed)
	);

	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (q_head.count != 4'd0 && q_head.count <= 4'd8))
		else $error("queued command has an invalid beat count");

	a_malformed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && malformed && !(pop && out_last)) |=> (empty || malformed))
		else $error("malformed flag dropped within a segment");

	a_first_time_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && first_time_valid && !(pop && out_last)) |=>
		(empty || (first_time_valid && first_time_before == $past(first_time_before))))
		else $error("captured first decode time changed within a segment");

endmodule

[src/fdtr_front.sv]
// Box parser classifying each byte; it queues at most one command per byte.
module fdtr_front #(
	parameter int NEST_DEPTH = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic [7:0]     data_byte,
	input  logic           end_of_segment,
	input  logic [63:0]    delta,
	output logic           cmd_valid,
	output fdtr_pkg::cmd_t cmd
);
	import fdtr_pkg::*;

	localparam int LVL_W = $clog2(NEST_DEPTH);

	logic [31:0]      rem_q [NEST_DEPTH];
	logic [31:0]      rem_n [NEST_DEPTH];
	logic [LVL_W-1:0] lvl_q, lvl_n, keep;
	logic [3:0]       hc_q, hc_n;
	logic [31:0]      size_q, size_n, type_q, type_n, body;
	logic [3:0]       fp_q, fp_n, len_q, len_n, rel_cnt;
	logic             wide_q, wide_n;
	logic [63:0]      ts_q, ts_n, sum, newt;
	logic             saved_q, saved_n, err_q, err_n;
	logic [63:0]      before_q, before_n, after_q, after_n;
	logic             emit_b, complete, rel;

	assign len_q = wide_q ? TIME_LEN_WIDE : TIME_LEN_NARROW;
	assign len_n = wide_n ? TIME_LEN_WIDE : TIME_LEN_NARROW;
	assign sum = {ts_q[55:0], data_byte} + delta;
	assign newt = wide_q ? sum : {32'd0, sum[31:0]};

	always_comb begin
		rem_n = rem_q;
		lvl_n = lvl_q;
		hc_n = hc_q;
		size_n = size_q;
		type_n = type_q;
		fp_n = fp_q;
		wide_n = wide_q;
		ts_n = ts_q;
		saved_n = saved_q;
		before_n = before_q;
		after_n = after_q;
		err_n = err_q;
		emit_b = 1'b0;
		complete = 1'b0;
		rel = 1'b0;
		rel_cnt = 4'd0;
		body = 32'd0;
		keep = '0;
		if (err_q) begin
			emit_b = 1'b1;
		end else if (hc_q < HDR_LEN) begin
			emit_b = 1'b1;
			for (int k = 0; k < NEST_DEPTH; k++) begin
				if (k < int'(lvl_q) && rem_q[k] != 32'd0) begin
					rem_n[k] = rem_q[k] - 32'd1;
				end
			end
			if (hc_q < PREFIX_LEN) begin
				size_n = {size_q[23:0], data_byte};
			end else begin
				type_n = {type_q[23:0], data_byte};
			end
			hc_n = hc_q + 4'd1;
			if (hc_n == HDR_LEN) begin
				if (size_n < 32'd8) begin
					err_n = 1'b1;
				end else begin
					body = size_n - 32'd8;
					if (lvl_q != '0 && body > rem_n[lvl_q - 1'b1]) begin
						body = rem_n[lvl_q - 1'b1];
					end
					rem_n[lvl_q] = body;
					fp_n = 4'd0;
					ts_n = 64'd0;
					if ((type_n == TYPE_MOOF || type_n == TYPE_TRAF) &&
					    (int'(lvl_q) + 1) < NEST_DEPTH) begin
						lvl_n = lvl_q + 1'b1;
						hc_n = 4'd0;
					end else if (body == 32'd0) begin
						hc_n = 4'd0;
					end
				end
			end
		end else begin
			for (int k = 0; k < NEST_DEPTH; k++) begin
				if (k <= int'(lvl_q) && rem_q[k] != 32'd0) begin
					rem_n[k] = rem_q[k] - 32'd1;
				end
			end
			if (type_q == TYPE_TFDT) begin
				if (fp_q == 4'd0) begin
					wide_n = (data_byte == 8'd1);
					fp_n = 4'd1;
					emit_b = 1'b1;
				end else if (fp_q < PREFIX_LEN || fp_q >= PREFIX_LEN + len_q) begin
					if (fp_q < PREFIX_LEN) begin
						fp_n = fp_q + 4'd1;
					end
					emit_b = 1'b1;
				end else begin
					ts_n = {ts_q[55:0], data_byte};
					fp_n = fp_q + 4'd1;
					if (fp_n == PREFIX_LEN + len_q) begin
						complete = 1'b1;
						if (!saved_q) begin
							saved_n = 1'b1;
							before_n = ts_n;
							after_n = newt;
						end
					end
				end
			end else begin
				emit_b = 1'b1;
			end
			if (rem_n[lvl_q] == 32'd0) begin
				if (type_q == TYPE_TFDT && fp_n > PREFIX_LEN && fp_n < PREFIX_LEN + len_n) begin
					rel = 1'b1;
					rel_cnt = fp_n - PREFIX_LEN;
				end
				hc_n = 4'd0;
				fp_n = 4'd0;
			end
		end
		if (!err_n) begin
			for (int j = 0; j < NEST_DEPTH - 1; j++) begin
				if (j < int'(lvl_n) && rem_n[j] != 32'd0) begin
					keep = LVL_W'(j + 1);
				end
			end
			if (keep != lvl_n) begin
				lvl_n = keep;
				hc_n = 4'd0;
				fp_n = 4'd0;
			end
		end
		if (end_of_segment && !err_n && !rel && type_n == TYPE_TFDT && hc_n == HDR_LEN &&
		    fp_n > PREFIX_LEN && fp_n < PREFIX_LEN + len_n) begin
			rel = 1'b1;
			rel_cnt = fp_n - PREFIX_LEN;
		end
	end

	assign cmd_valid = in_fire && (emit_b || complete || rel);

	always_comb begin
		if (rel) begin
			cmd.word = ts_n;
			cmd.count = rel_cnt;
		end else if (complete) begin
			cmd.word = newt;
			cmd.count = len_q;
		end else begin
			cmd.word = {56'd0, data_byte};
			cmd.count = 4'd1;
		end
		cmd.last = end_of_segment;
		cmd.first_valid = saved_n;
		cmd.time_before = before_n;
		cmd.after = after_n;
		cmd.malformed = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NEST_DEPTH; k++) begin
				rem_q[k] <= 32'd0;
			end
			lvl_q <= '0;
			hc_q <= 4'd0;
			size_q <= 32'd0;
			type_q <= 32'd0;
			fp_q <= 4'd0;
			wide_q <= 1'b0;
			ts_q <= 64'd0;
			saved_q <= 1'b0;
			before_q <= 64'd0;
			after_q <= 64'd0;
			err_q <= 1'b0;
		end else if (in_fire) begin
			if (end_of_segment) begin
				for (int k = 0; k < NEST_DEPTH; k++) begin
					rem_q[k] <= 32'd0;
				end
				lvl_q <= '0;
				hc_q <= 4'd0;
				size_q <= 32'd0;
				type_q <= 32'd0;
				fp_q <= 4'd0;
				wide_q <= 1'b0;
				ts_q <= 64'd0;
				saved_q <= 1'b0;
				before_q <= 64'd0;
				after_q <= 64'd0;
				err_q <= 1'b0;
			end else begin
				rem_q <= rem_n;
				lvl_q <= lvl_n;
				hc_q <= hc_n;
				size_q <= size_n;
				type_q <= type_n;
				fp_q <= fp_n;
				wide_q <= wide_n;
				ts_q <= ts_n;
				saved_q <= saved_n;
				before_q <= before_n;
				after_q <= after_n;
				err_q <= err_n;
			end
		end
	end

endmodule

[src/fdtr_queue.sv]
// Short command queue between the parser and the byte serializer.
module fdtr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  fdtr_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd_en,
	output fdtr_pkg::cmd_t rd_cmd,
	output logic           empty
);
	import fdtr_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/fdtr_back.sv]
// Serializer that turns queued commands into output beats through a result register.
module fdtr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  fdtr_pkg::cmd_t cmd,
	output logic           cmd_rd,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           out_last,
	output logic           first_time_valid,
	output logic [63:0]    first_time_before,
	output logic [63:0]    first_time_after,
	output logic           malformed
);
	import fdtr_pkg::*;

	logic [2:0]  idx_q, sel;
	logic        out_valid_q, load, last_byte;
	logic [63:0] shifted;

	assign sel = 3'(cmd.count - 4'd1 - {1'b0, idx_q});
	assign shifted = cmd.word >> {sel, 3'b000};
	assign last_byte = (({1'b0, idx_q} + 4'd1) == cmd.count);
	assign load = !cmd_empty && (!out_valid_q || pop);
	assign cmd_rd = load && last_byte;
	assign empty = !out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= shifted[7:0];
			out_last <= cmd.last && last_byte;
			first_time_valid <= cmd.first_valid;
			first_time_before <= cmd.time_before;
			first_time_after <= cmd.after;
			malformed <= cmd.malformed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_byte ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
